>>> rtl/assert_macros.svh
// Assertion macros shared by the entity codec modules.
// Depends on clk and rst_n being visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define HEC_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define HEC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define HEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hec_pkg.sv
// Types, codes and the entity table of the entity codec.
// No dependencies; used by hec_regs, hec_ctrl, hec_dpath and the top level.
package hec_pkg;

    typedef logic [7:0] byte_t;

    localparam int NUM_ENT     = 26;
    localparam int ACC_ENT     = 22;
    localparam int ENT_MAX_LEN = 8;
    localparam int ENT_IDX_W   = $clog2(NUM_ENT);
    localparam int ADDR_W      = 3;

    typedef logic [ENT_IDX_W-1:0] ent_idx_t;

    localparam byte_t AMP_CHAR  = 8'h26;
    localparam byte_t SEMI_CHAR = 8'h3B;

    localparam logic [1:0] DIR_PASS   = 2'd0;
    localparam logic [1:0] DIR_DECODE = 2'd1;
    localparam logic [1:0] DIR_ENCODE = 2'd2;

    localparam logic REG_DIRECTION = 1'b0;
    localparam logic REG_XML       = 1'b1;

    localparam byte_t ENT_CODE [NUM_ENT] = '{
        8'h85, 8'hA0, 8'h83, 8'h8A, 8'h82, 8'h88, 8'h8D, 8'hA1, 8'h8C,
        8'h95, 8'hA2, 8'h93, 8'h97, 8'hA3, 8'h96, 8'h87, 8'h81, 8'h84,
        8'h94, 8'h9A, 8'h8E, 8'h99, 8'h3C, 8'h3E, 8'h26, 8'h22
    };

    localparam logic [3:0] ENT_LEN [NUM_ENT] = '{
        4'd8, 4'd8, 4'd7, 4'd8, 4'd8, 4'd7, 4'd8, 4'd8, 4'd7,
        4'd8, 4'd8, 4'd7, 4'd8, 4'd8, 4'd7, 4'd8, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd6, 4'd4, 4'd4, 4'd5, 4'd6
    };

    // Left-justified entity text, first character in the top byte.
    localparam logic [63:0] ENT_TEXT [NUM_ENT] = '{
        "&agrave;", "&aacute;", {"&acirc;", 8'h00},
        "&egrave;", "&eacute;", {"&ecirc;", 8'h00},
        "&igrave;", "&iacute;", {"&icirc;", 8'h00},
        "&ograve;", "&oacute;", {"&ocirc;", 8'h00},
        "&ugrave;", "&uacute;", {"&ucirc;", 8'h00},
        "&ccedil;", {"&uuml;", 16'h0000}, {"&auml;", 16'h0000},
        {"&ouml;", 16'h0000}, {"&Uuml;", 16'h0000}, {"&Auml;", 16'h0000},
        {"&Ouml;", 16'h0000},
        {"&lt;", 32'h0000_0000}, {"&gt;", 32'h0000_0000}, {"&amp;", 24'h00_0000},
        {"&quot;", 16'h0000}
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_TAIL,
        ST_ENC
    } state_t;

    typedef enum logic [1:0] {
        TAIL_IN,
        TAIL_CODE,
        TAIL_AMP
    } tail_sel_t;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_CLEAR,
        CNT_ONE,
        CNT_INCR
    } cnt_op_t;

    typedef struct packed {
        logic      load;
        logic      store;
        cnt_op_t   cnt_op;
        tail_sel_t tail_sel;
        logic      tail_after;
        logic      advance;
        state_t    phase;
    } hec_cmd_t;

    typedef struct packed {
        logic is_amp;
        logic is_semi;
        logic eos;
        logic held_zero;
        logic held_full;
        logic match_hit;
        logic enc_hit;
        logic seq_last;
        logic tail_pend;
        logic out_last;
    } hec_stat_t;

    function automatic byte_t ent_char(input ent_idx_t e, input logic [2:0] p);
        logic [63:0] txt;
        txt = ENT_TEXT[e];
        return txt[8*(7-int'(p)) +: 8];
    endfunction

endpackage

>>> rtl/hec_in_if.sv
// Input byte channel of the entity codec: valid/ready plus one text byte.
// No dependencies.
interface hec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_string;

    modport source (output valid, output data_byte, output end_of_string, input ready);
    modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

>>> rtl/hec_out_if.sv
// Result byte channel of the entity codec: valid/ready plus one converted byte.
// No dependencies.
interface hec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

>>> rtl/hec_regs.sv
// APB-style configuration registers: direction and XML entity enable.
// Depends on hec_pkg.
module hec_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [hec_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output logic [1:0]                direction,
    output logic                      xml,
    output logic                      dir_wr
);
    import hec_pkg::*;

    logic [1:0] direction_reg;
    logic       xml_reg;
    logic       wr_en;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign dir_wr    = wr_en && (paddr[2] == REG_DIRECTION);
    assign direction = direction_reg;
    assign xml       = xml_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_PASS;
            xml_reg       <= 1'b0;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_DIRECTION: direction_reg <= pwdata[1:0];
                REG_XML:       xml_reg       <= pwdata[0];
                default:       xml_reg       <= xml_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_DIRECTION: prdata = {30'd0, direction_reg};
            REG_XML:       prdata = {31'd0, xml_reg};
            default:       prdata = '0;
        endcase
    end

endmodule

>>> rtl/hec_ctrl.sv
// Controller of the entity codec: decides per byte and sequences result beats.
// Depends on hec_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hec_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  logic [1:0]          direction,
    input  hec_pkg::hec_stat_t  stat,
    output hec_pkg::hec_cmd_t   cmd
);
    import hec_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        cmd.load       = 1'b0;
        cmd.store      = 1'b0;
        cmd.cnt_op     = CNT_KEEP;
        cmd.tail_sel   = TAIL_IN;
        cmd.tail_after = 1'b0;
        cmd.advance    = 1'b0;
        cmd.phase      = state_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (direction)
                        DIR_DECODE:
                        begin
                            if (stat.is_amp)
                            begin
                                cmd.tail_sel   = TAIL_AMP;
                                cmd.tail_after = stat.eos;
                                cmd.cnt_op     = stat.eos ? CNT_CLEAR : CNT_ONE;
                                if (!stat.held_zero)
                                begin
                                    state_next = ST_FLUSH;
                                end
                                else if (stat.eos)
                                begin
                                    state_next = ST_TAIL;
                                end
                            end
                            else if (stat.held_zero)
                            begin
                                state_next = ST_TAIL;
                            end
                            else if (stat.is_semi)
                            begin
                                cmd.cnt_op = CNT_CLEAR;
                                if (stat.match_hit)
                                begin
                                    cmd.tail_sel = TAIL_CODE;
                                    state_next   = ST_TAIL;
                                end
                                else
                                begin
                                    cmd.tail_after = 1'b1;
                                    state_next     = ST_FLUSH;
                                end
                            end
                            else if (!stat.held_full)
                            begin
                                cmd.store = 1'b1;
                                if (stat.eos)
                                begin
                                    cmd.cnt_op = CNT_CLEAR;
                                    state_next = ST_FLUSH;
                                end
                                else
                                begin
                                    cmd.cnt_op = CNT_INCR;
                                end
                            end
                            else
                            begin
                                cmd.cnt_op     = CNT_CLEAR;
                                cmd.tail_after = 1'b1;
                                state_next     = ST_FLUSH;
                            end
                        end
                        DIR_ENCODE:
                        begin
                            state_next = stat.enc_hit ? ST_ENC : ST_TAIL;
                        end
                        default:
                        begin
                            state_next = ST_TAIL;
                        end
                    endcase
                end
            end
            ST_FLUSH:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.advance = 1'b1;
                    if (stat.seq_last)
                    begin
                        state_next = stat.tail_pend ? ST_TAIL : ST_IDLE;
                    end
                end
            end
            ST_ENC:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.advance = 1'b1;
                    if (stat.seq_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TAIL:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `HEC_ASSERT_NEXT(a_tail_after_flush, state_reg == ST_FLUSH && out_ready && stat.seq_last && stat.tail_pend, state_reg == ST_TAIL, "flush with pending byte did not go to tail")
    `HEC_ASSERT_NEXT(a_last_frees_input, out_valid && out_ready && stat.out_last, in_ready, "input not taken after last beat")
    `HEC_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !stat.out_last, out_valid, "run ended without last beat")

endmodule

>>> rtl/hec_dpath.sv
// Datapath of the entity codec: held group memory, match tracking, beat mux.
// Depends on hec_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hec_dpath #(
    parameter int HOLD_DEPTH = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          in_byte,
    input  logic                in_eos,
    input  logic                xml,
    input  logic                dir_wr,
    input  hec_pkg::hec_cmd_t   cmd,
    output hec_pkg::hec_stat_t  stat,
    output logic [7:0]          out_byte,
    output logic                out_last
);
    import hec_pkg::*;

    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam int IDX_W = $clog2(HOLD_DEPTH);
    localparam int MEM_D = 2 ** IDX_W;

    byte_t              mem [MEM_D];
    logic [CNT_W-1:0]   held_cnt_reg;
    logic [CNT_W-1:0]   held_cnt_next;
    logic [CNT_W-1:0]   pos_reg;
    logic [CNT_W-1:0]   pos_next;
    logic [CNT_W-1:0]   flush_cnt_reg;
    logic [NUM_ENT-1:0] cand_reg;
    logic [NUM_ENT-1:0] cand_next;
    logic [NUM_ENT-1:0] active;
    logic [NUM_ENT-1:0] match_vec;
    logic [NUM_ENT-1:0] enc_vec;
    byte_t              rd_data_reg;
    byte_t              byte_reg;
    byte_t              byte_next;
    byte_t              match_code;
    ent_idx_t           ent_reg;
    ent_idx_t           match_idx;
    ent_idx_t           enc_idx;
    logic               tail_reg;
    logic               seq_last;

    always_comb
    begin
        match_idx = '0;
        enc_idx   = '0;
        for (int e = 0; e < NUM_ENT; e++)
        begin
            active[e]    = xml || (e < ACC_ENT);
            match_vec[e] = cand_reg[e] && active[e]
                           && (int'(ENT_LEN[e]) == int'(held_cnt_reg) + 1);
            enc_vec[e]   = active[e] && (ENT_CODE[e] == in_byte);
            cand_next[e] = cand_reg[e] && (int'(held_cnt_reg) < ENT_MAX_LEN)
                           && (ent_char(ENT_IDX_W'(e), held_cnt_reg[2:0]) == in_byte);
        end
        for (int e = NUM_ENT - 1; e >= 0; e--)
        begin
            if (match_vec[e])
            begin
                match_idx = ENT_IDX_W'(e);
            end
            if (enc_vec[e])
            begin
                enc_idx = ENT_IDX_W'(e);
            end
        end
        match_code = ENT_CODE[match_idx];
    end

    always_comb
    begin
        case (cmd.tail_sel)
            TAIL_CODE: byte_next = match_code;
            TAIL_AMP:  byte_next = AMP_CHAR;
            default:   byte_next = in_byte;
        endcase

        held_cnt_next = held_cnt_reg;
        if (dir_wr)
        begin
            held_cnt_next = '0;
        end
        else if (cmd.load)
        begin
            case (cmd.cnt_op)
                CNT_CLEAR: held_cnt_next = '0;
                CNT_ONE:   held_cnt_next = CNT_W'(1);
                CNT_INCR:  held_cnt_next = held_cnt_reg + CNT_W'(1);
                default:   held_cnt_next = held_cnt_reg;
            endcase
        end

        if (cmd.load)
        begin
            pos_next = '0;
        end
        else if (cmd.advance)
        begin
            pos_next = pos_reg + CNT_W'(1);
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg <= '0;
            tail_reg     <= 1'b0;
        end
        else
        begin
            held_cnt_reg <= held_cnt_next;
            if (cmd.load)
            begin
                tail_reg <= cmd.tail_after;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        if (cmd.load)
        begin
            byte_reg      <= byte_next;
            ent_reg       <= enc_idx;
            flush_cnt_reg <= held_cnt_reg + CNT_W'(cmd.store);
        end
        if (cmd.load && (cmd.cnt_op == CNT_ONE))
        begin
            cand_reg <= '1;
        end
        else if (cmd.load && cmd.store)
        begin
            cand_reg <= cand_next;
        end
    end

    // Slot zero is never stored; the beat mux puts out the opening ampersand in its place.
    always_ff @(posedge clk)
    begin
        if (cmd.load && cmd.store)
        begin
            mem[held_cnt_reg[IDX_W-1:0]] <= in_byte;
        end
        rd_data_reg <= mem[pos_next[IDX_W-1:0]];
    end

    always_comb
    begin
        case (cmd.phase)
            ST_FLUSH:
            begin
                seq_last = (pos_reg + CNT_W'(1)) == flush_cnt_reg;
                out_byte = (pos_reg == '0) ? AMP_CHAR : rd_data_reg;
                out_last = seq_last && !tail_reg;
            end
            ST_ENC:
            begin
                seq_last = pos_reg[2:0] == 3'(ENT_LEN[ent_reg] - 4'd1);
                out_byte = ent_char(ent_reg, pos_reg[2:0]);
                out_last = seq_last;
            end
            ST_TAIL:
            begin
                seq_last = 1'b1;
                out_byte = byte_reg;
                out_last = 1'b1;
            end
            default:
            begin
                seq_last = 1'b0;
                out_byte = byte_reg;
                out_last = 1'b0;
            end
        endcase
    end

    assign stat.is_amp    = in_byte == AMP_CHAR;
    assign stat.is_semi   = in_byte == SEMI_CHAR;
    assign stat.eos       = in_eos;
    assign stat.held_zero = held_cnt_reg == '0;
    assign stat.held_full = held_cnt_reg == CNT_W'(HOLD_DEPTH);
    assign stat.match_hit = |match_vec;
    assign stat.enc_hit   = |enc_vec;
    assign stat.seq_last  = seq_last;
    assign stat.tail_pend = tail_reg;
    assign stat.out_last  = out_last;

    `HEC_ASSERT(a_held_range, held_cnt_reg <= CNT_W'(HOLD_DEPTH), "held count beyond depth")
    `HEC_ASSERT_IMPL(a_flush_nonempty, cmd.phase == ST_FLUSH, flush_cnt_reg != '0, "empty flush")
    `HEC_ASSERT_IMPL(a_enc_active, cmd.phase == ST_ENC, xml || (int'(ent_reg) < ACC_ENT), "inactive entity encoded")

endmodule

>>> rtl/html_entity_codec.sv
// A byte is taken when the block is idle; its result beats follow from the next cycle, one per
// cycle while the output is ready: 1 for pass or a decoded byte, 4 to 8 for an entity, and up to
// held count plus one for a flush. A new byte is taken only after the last result beat of the
// byte before it has been accepted; a byte that is only held gives no beats and leaves it idle.
// Reset: pass mode, XML entries off, nothing held.
// Top level of the entity codec; depends on hec_pkg, hec_in_if, hec_out_if and submodules.
module html_entity_codec #(
    parameter int HOLD_DEPTH = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hec_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    hec_in_if.sink                     feed,
    hec_out_if.source                  result
);
    import hec_pkg::*;

    logic [1:0] direction;
    logic       xml;
    logic       dir_wr;
    hec_cmd_t   cmd;
    hec_stat_t  stat;

    hec_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .direction (direction),
        .xml       (xml),
        .dir_wr    (dir_wr)
    );

    hec_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (feed.valid),
        .in_ready  (feed.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .direction (direction),
        .stat      (stat),
        .cmd       (cmd)
    );

    hec_dpath #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_byte  (feed.data_byte),
        .in_eos   (feed.end_of_string),
        .xml      (xml),
        .dir_wr   (dir_wr),
        .cmd      (cmd),
        .stat     (stat),
        .out_byte (result.out_byte),
        .out_last (result.last_of_run)
    );

endmodule
